// ===== hw/rtl/dart_pkg.sv =====
// Shared types and constants for the divider and reload timer.
// No dependencies; used by dart_core, dart_outbuf and divider_and_reload_timer.
package dart_pkg;

    localparam int TICK_W = 10;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SELECT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_VALUE = 2'd2;

    localparam logic [1:0] RATE_SEL_1024 = 2'd0;
    localparam logic [1:0] RATE_SEL_16   = 2'd1;
    localparam logic [1:0] RATE_SEL_64   = 2'd2;
    localparam logic [1:0] RATE_SEL_256  = 2'd3;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic       enable;
        logic [1:0] rate_select;
        logic [7:0] reload_value;
    } timer_cfg_t;

    typedef struct packed {
        logic       timer_irq;
        logic [7:0] timer_value;
        logic [7:0] divider_value;
        logic       cpu_step;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hw/rtl/divider_and_reload_timer.sv =====
// Divider and reload timer: one master tick per input beat with advance set, one result beat per input beat.
// The result of an accepted beat is registered in the main register, or in the skid register while one waits.
// One beat is taken per cycle while the skid stage is empty; the counters update in a single pass before the
// result register, and a skid stage keeps s_tready high while one result waits.
// Reset (aresetn low, synchronous) clears all counters and configuration and empties the output buffers.
// Depends on dart_pkg, dart_core and dart_outbuf.
module divider_and_reload_timer import dart_pkg::*; #(
    parameter int CPU_DIV = 4,
    parameter int DIV_DIV = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] advance, [7:1] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] cpu_step, [8:1] divider_value,
                                              // [16:9] timer_value, [17] timer_irq, [23:18] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    timer_cfg_t cfg_reg, cfg_next;
    result_t    core_result;
    result_t    out_result;
    logic       s_accept;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMER_ENABLE: cfg_next.enable       = cfg_data[0];
                CFG_RATE_SELECT:  cfg_next.rate_select  = cfg_data[1:0];
                CFG_RELOAD_VALUE: cfg_next.reload_value = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dart_core #(
        .CPU_DIV(CPU_DIV),
        .DIV_DIV(DIV_DIV)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_accept(s_accept),
        .advance    (s_tdata[0]),
        .cfg        (cfg_reg),
        .result     (core_result)
    );

    dart_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (core_result),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_result)
    );

    assign m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_result};

    a_irq_reloads: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result.timer_irq |-> out_result.timer_value == cfg_reg.reload_value)
        else $error("timer interrupt without reload of the timer counter");

    a_irq_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result.timer_irq |-> cfg_reg.enable)
        else $error("timer interrupt while the timer is disabled");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !m_tvalid |=> m_tvalid)
        else $error("accepted beat produced no result");

endmodule

// ===== hw/rtl/dart_core.sv =====
// Tick counter, phase counters, divider and timer counter for one tick per beat with advance set.
// Depends on dart_pkg.
module dart_core import dart_pkg::*; #(
    parameter int CPU_DIV = 4,
    parameter int DIV_DIV = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_accept,
    input  logic       advance,
    input  timer_cfg_t cfg,
    output result_t    result
);

    localparam int CPU_W = (CPU_DIV > 1) ? $clog2(CPU_DIV) : 1;
    localparam int DIV_W = (DIV_DIV > 1) ? $clog2(DIV_DIV) : 1;
    localparam logic [CPU_W-1:0] CPU_LAST = CPU_W'(CPU_DIV - 1);
    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DIV_DIV - 1);

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CPU_W-1:0]  cpu_phase_reg, cpu_phase_next;
    logic [DIV_W-1:0]  div_phase_reg, div_phase_next;
    logic [7:0]        divider_reg, divider_next;
    logic [7:0]        timer_reg, timer_next;
    logic              tick;
    logic              rate_hit;
    logic              cpu_hit;
    logic              div_hit;
    logic              timer_hit;
    logic              timer_wrap;

    assign tick    = item_accept && advance;
    assign cpu_hit = (cpu_phase_reg == '0);
    assign div_hit = (div_phase_reg == '0);

    always_comb begin
        case (cfg.rate_select)
            RATE_SEL_1024: rate_hit = (tick_reg == '0);
            RATE_SEL_16:   rate_hit = (tick_reg[3:0] == '0);
            RATE_SEL_64:   rate_hit = (tick_reg[5:0] == '0);
            RATE_SEL_256:  rate_hit = (tick_reg[7:0] == '0);
            default:       rate_hit = 1'b0;
        endcase
    end

    assign timer_hit  = cfg.enable && rate_hit;
    assign timer_wrap = timer_hit && (timer_reg == 8'hFF);

    always_comb begin
        tick_next      = tick_reg;
        cpu_phase_next = cpu_phase_reg;
        div_phase_next = div_phase_reg;
        divider_next   = divider_reg;
        timer_next     = timer_reg;
        if (tick) begin
            tick_next = tick_reg + 1'b1;
            if (tick_reg == TICK_MAX || cpu_phase_reg == CPU_LAST) begin
                cpu_phase_next = '0;
            end else begin
                cpu_phase_next = cpu_phase_reg + 1'b1;
            end
            if (tick_reg == TICK_MAX || div_phase_reg == DIV_LAST) begin
                div_phase_next = '0;
            end else begin
                div_phase_next = div_phase_reg + 1'b1;
            end
            if (div_hit) begin
                divider_next = divider_reg + 1'b1;
            end
            if (timer_wrap) begin
                timer_next = cfg.reload_value;
            end else if (timer_hit) begin
                timer_next = timer_reg + 1'b1;
            end
        end
    end

    always_comb begin
        result.cpu_step      = tick && cpu_hit;
        result.divider_value = divider_next;
        result.timer_value   = timer_next;
        result.timer_irq     = tick && timer_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            cpu_phase_reg <= '0;
            div_phase_reg <= '0;
            divider_reg   <= '0;
            timer_reg     <= '0;
        end else begin
            tick_reg      <= tick_next;
            cpu_phase_reg <= cpu_phase_next;
            div_phase_reg <= div_phase_next;
            divider_reg   <= divider_next;
            timer_reg     <= timer_next;
        end
    end

endmodule

// ===== hw/rtl/dart_outbuf.sv =====
// Result register with a skid stage, so a new beat is taken while a result waits.
// Depends on dart_pkg.
module dart_outbuf import dart_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== dv/divider_and_reload_timer_tb.sv =====
// Self-checking testbench for divider_and_reload_timer: directed beats, then randomized
// register phases with bursty input and a stalling result side, checked against a predictor.
// Depends on dart_pkg and the divider_and_reload_timer RTL.
`timescale 1ns / 1ps

module divider_and_reload_timer_tb;
    import dart_pkg::*;

    localparam int CPU_STEP_DIV = 4;
    localparam int DIVIDER_DIV  = 256;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int N_DIRECTED = 20;
    localparam int N_PHASES   = 6;

    typedef struct packed {
        logic       adv;
        logic       pinned;
        logic       irq;
        logic [7:0] tmr;
        logic [7:0] div;
        logic       cpu;
    } row_t;

    typedef struct packed {
        logic        en;
        logic [1:0]  rate;
        logic [7:0]  reload;
        int unsigned beats;
    } phase_t;

    typedef struct {
        result_t predicted;
        logic    pinned;
        result_t pinned_val;
    } tick_result_t;

    localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 8'd0, 8'd1, 1'b1},
        '{1'b0, 1'b1, 1'b0, 8'd0, 8'd1, 1'b0},
        '{1'b1, 1'b1, 1'b0, 8'd0, 8'd1, 1'b0},
        '{1'b1, 1'b1, 1'b0, 8'd0, 8'd1, 1'b0},
        '{1'b1, 1'b1, 1'b0, 8'd0, 8'd1, 1'b0},
        '{1'b1, 1'b1, 1'b0, 8'd0, 8'd1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}
    };

    localparam phase_t PHASES [N_PHASES] = '{
        '{1'b1, RATE_SEL_16,   8'hFF, 200},
        '{1'b1, RATE_SEL_16,   8'h00, 150},
        '{1'b1, RATE_SEL_64,   8'hC0, 300},
        '{1'b1, RATE_SEL_256,  8'h80, 300},
        '{1'b0, RATE_SEL_1024, 8'h55, 200},
        '{1'b1, RATE_SEL_1024, 8'h01, 300}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic    beat_pinned;
    result_t beat_pinned_val;

    timer_cfg_t       model_cfg   = '0;
    logic [TICK_W-1:0] model_ticks = '0;
    logic [7:0]       model_div   = '0;
    logic [7:0]       model_tmr   = '0;

    tick_result_t pending_results[$];
    int unsigned  mismatches      = 0;
    int unsigned  results_seen    = 0;
    int unsigned  burst_left      = 0;
    logic         long_stall_done = 1'b0;

    divider_and_reload_timer #(
        .CPU_DIV(CPU_STEP_DIV),
        .DIV_DIV(DIVIDER_DIV)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic result_t predict_tick(logic adv);
        result_t     r;
        int unsigned period;
        r = '0;
        if (adv) begin
            case (model_cfg.rate_select)
                RATE_SEL_16:  period = 16;
                RATE_SEL_64:  period = 64;
                RATE_SEL_256: period = 256;
                default:      period = 1024;
            endcase
            if (model_ticks % CPU_STEP_DIV == 0) r.cpu_step = 1'b1;
            if (model_ticks % DIVIDER_DIV == 0) model_div = model_div + 8'd1;
            if (model_cfg.enable && model_ticks % period == 0) begin
                model_tmr = model_tmr + 8'd1;
                if (model_tmr == 8'd0) begin
                    model_tmr = model_cfg.reload_value;
                    r.timer_irq = 1'b1;
                end
            end
            model_ticks = model_ticks + 1'b1;
        end
        r.divider_value = model_div;
        r.timer_value = model_tmr;
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic compare_result(result_t got, result_t want, string tag);
        if (got.cpu_step != want.cpu_step)
            report_mismatch({tag, " cpu_step"}, got.cpu_step, want.cpu_step);
        if (got.divider_value != want.divider_value)
            report_mismatch({tag, " divider_value"}, got.divider_value, want.divider_value);
        if (got.timer_value != want.timer_value)
            report_mismatch({tag, " timer_value"}, got.timer_value, want.timer_value);
        if (got.timer_irq != want.timer_irq)
            report_mismatch({tag, " timer_irq"}, got.timer_irq, want.timer_irq);
    endtask

    always @(posedge aclk) begin
        tick_result_t entry;
        result_t      got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending", got, 0);
                end else begin
                    entry = pending_results.pop_front();
                    compare_result(got, entry.predicted, "predicted");
                    if (entry.pinned) compare_result(got, entry.pinned_val, "directed");
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIMER_ENABLE: model_cfg.enable = cfg_data[0];
                    CFG_RATE_SELECT:  model_cfg.rate_select = cfg_data[1:0];
                    CFG_RELOAD_VALUE: model_cfg.reload_value = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                entry.predicted = predict_tick(s_tdata[0]);
                entry.pinned = beat_pinned;
                entry.pinned_val = beat_pinned_val;
                pending_results.push_back(entry);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_beat(logic adv, logic pinned, result_t want);
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(adv);
        beat_pinned <= pinned;
        beat_pinned_val <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_idle();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!long_stall_done && results_seen >= 500) begin
                long_stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (150) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if ($urandom_range(0, 2) != 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        row_t        row;
        phase_t      ph;
        int unsigned sent;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        beat_pinned = 1'b0;
        beat_pinned_val = '0;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            send_beat(row.adv, row.pinned, {row.irq, row.tmr, row.div, row.cpu});
            sender_idle();
        end
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            ph = PHASES[p];
            write_reg(CFG_TIMER_ENABLE, {7'($urandom), ph.en});
            write_reg(CFG_RATE_SELECT, {6'($urandom), ph.rate});
            write_reg(CFG_RELOAD_VALUE, ph.reload);
            write_reg(CFG_UNUSED, 8'($urandom));
            sent = 0;
            while (sent < ph.beats) begin
                send_beat($urandom_range(0, 99) < 85, 1'b0, '0);
                sent++;
                sender_idle();
            end
            drain_results();
        end

        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
